// File: design/brg_pkg.sv
// ============================================================================
// brg_pkg: shared types and constants
// Field widths, register indexes and divider control types for the
// averaged battery ratio gauge.
// ============================================================================
`default_nettype none

package brg_pkg;

    // Field widths
    localparam int TAP_W      = 12;
    localparam int CODE_W     = 12;
    localparam int REFMV_W    = 12;
    localparam int NOM_W      = 12;
    localparam int THR_W      = 12;
    localparam int EMPTY_W    = 13;
    localparam int MV_W       = 14;
    localparam int PCT_W      = 7;

    // Fixed-point value: tap(12) * nominal(12) * 2 with 8 fraction bits
    localparam int FRAC_BITS  = 8;
    localparam int Q_W        = TAP_W + NOM_W + 1 + FRAC_BITS;
    localparam int DVS_W      = 12;
    localparam int CNT_W      = $clog2(Q_W + 1);

    localparam int WINDOW_DEF = 8;

    localparam logic [MV_W-1:0]  MV_MAX   = 14'd16383;
    localparam logic [MV_W-1:0]  FULL_MV  = 14'd4200;
    localparam logic [PCT_W-1:0] PCT_MAX  = 7'd100;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_ADDR_W-1:0] CFG_REF_NOMINAL = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CHARGE_THR  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_EMPTY_MV    = 2'd2;

    localparam logic [NOM_W-1:0]   NOM_RESET   = 12'd1650;
    localparam logic [THR_W-1:0]   THR_RESET   = 12'd2300;
    localparam logic [EMPTY_W-1:0] EMPTY_RESET = 13'd3400;

    typedef struct packed {
        logic [REFMV_W-1:0] ref_mv;
        logic [TAP_W-1:0]   tap_mv;
    } sample_t;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] iters;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

// File: design/brg_cell.sv
// ============================================================================
// brg_cell: one sample cell of the averaging window
// Holds one tap/reference sample pair and hands it to the next cell on shift.
// ============================================================================
`default_nettype none

module brg_cell (
    input  wire              clk,
    input  wire              shift,
    input  brg_pkg::sample_t din,
    output brg_pkg::sample_t dout
);
    import brg_pkg::*;

    sample_t sample_reg;

    // Payload only: contents stay undefined until the first shift reaches it
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            sample_reg <= din;
        end
    end

    assign dout = sample_reg;

endmodule

`default_nettype wire

// File: design/brg_divider.sv
// ============================================================================
// brg_divider: shared restoring divider
// One quotient bit per cycle; the dividend is left-aligned and the number of
// iterations sets how many quotient bits are produced.
// ============================================================================
`default_nettype none

module brg_divider (
    input  wire                            clk,
    input  wire                            rst_n,
    input  brg_pkg::div_ctrl_t             ctrl,
    input  wire [brg_pkg::Q_W-1:0]         dividend,
    input  wire [brg_pkg::DVS_W-1:0]       divisor,
    output brg_pkg::div_stat_t             stat,
    output logic [brg_pkg::Q_W-1:0]        quotient
);
    import brg_pkg::*;

    logic [Q_W-1:0]   dvd_reg, dvd_next;
    logic [Q_W-1:0]   quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             fits;

    assign trial = {rem_reg, dvd_reg[Q_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start)
        begin
            dvd_next  = dividend;
            dvs_next  = divisor;
            quo_next  = '0;
            rem_next  = '0;
            cnt_next  = ctrl.iters;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[Q_W-2:0], 1'b0};
            quo_next = {quo_reg[Q_W-2:0], fits};
            rem_next = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

`default_nettype wire

// File: design/battery_ratio_gauge_averaged_core.sv
// ============================================================================
// battery_ratio_gauge_averaged_core: averaged battery gauge with ratio fix
// Moving-average battery voltage and percent estimate from tap and reference
// samples, with charging detection and change reporting.
// ============================================================================
// Usage:
//   Input stream (s_*): one beat per sample set; tdata carries tap_mv,
//   ref_code and ref_mv. Output stream (m_*): one beat per input beat with
//   battery_mv, percent, charging, changed and valid_res.
//   Config channel (cfg_*): always ready; cfg_addr selects ref_nominal_mv (0),
//   charge_raw_threshold (1) or empty_mv (2); other indexes are ignored.
//   Write it only while no sample is in flight.
// Sequencing:
//   One sample is worked at a time. A charging beat or one with zero
//   averaged reference skips the ratio division. Two window averages and
//   the ratio quotient run through the shared bit-serial divider in turn.
//   The next beat is accepted as soon as the previous result sits in the
//   output register, even if the receiver has not taken it yet.
// Reset:
//   Control registers return to their defaults, the window is empty, held
//   values are 4200 mV / 100 %; the first valid result is flagged changed.
// Stall:
//   A stalled output holds its beat; a finished result waits in the final
//   step until the output register frees up, and no new beat is taken.
// ============================================================================
`default_nettype none

module battery_ratio_gauge_averaged_core #(
    parameter int WINDOW = brg_pkg::WINDOW_DEF
) (
    input  wire                               clk,
    input  wire                               rst_n,
    // tdata: tap_mv[11:0], ref_code[23:12], ref_mv[35:24], zero fill [39:36]
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire [39:0]                        s_tdata,
    // tdata: battery_mv[13:0], percent[20:14], charging[21], changed[22],
    //        valid_res[23]
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [23:0]                       m_tdata,
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire [brg_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire [brg_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import brg_pkg::*;

    localparam int FILL_W    = $clog2(WINDOW + 1);
    localparam int SUM_W     = $clog2(((1 << TAP_W) - 1) * WINDOW + 1);
    localparam int AVG_SHIFT = Q_W - SUM_W;

    // Sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_TAP_GO   = 4'd1;
    localparam logic [3:0] S_TAP_WAIT = 4'd2;
    localparam logic [3:0] S_REF_GO   = 4'd3;
    localparam logic [3:0] S_REF_WAIT = 4'd4;
    localparam logic [3:0] S_MUL      = 4'd5;
    localparam logic [3:0] S_Q_GO     = 4'd6;
    localparam logic [3:0] S_Q_WAIT   = 4'd7;
    localparam logic [3:0] S_FIN      = 4'd8;

    logic [3:0] state_reg, state_next;

    // Configuration registers
    logic [NOM_W-1:0]   nom_reg;
    logic [THR_W-1:0]   thr_reg;
    logic [EMPTY_W-1:0] empty_reg;

    // Window bookkeeping
    logic [FILL_W-1:0] fill_reg;
    logic [SUM_W-1:0]  tap_sum_reg;
    logic [SUM_W-1:0]  ref_sum_reg;
    logic              charging_reg;

    // Working values
    logic [TAP_W-1:0]         avg_tap_reg;
    logic [REFMV_W-1:0]       avg_ref_reg;
    logic [TAP_W+NOM_W-1:0]   prod_reg;
    logic [Q_W-1:0]           q_reg;

    // Held and reported state
    logic [MV_W-1:0]  held_mv_reg;
    logic [PCT_W-1:0] held_pct_reg;
    logic [PCT_W-1:0] rep_pct_reg;
    logic             rep_valid_reg;
    logic             rep_chg_reg;

    logic             m_tvalid_reg;
    logic [23:0]      m_tdata_reg;

    // Input unpacking
    logic [TAP_W-1:0]   in_tap;
    logic [CODE_W-1:0]  in_code;
    logic [REFMV_W-1:0] in_ref;
    logic               s_accept;

    assign in_tap   = s_tdata[11:0];
    assign in_code  = s_tdata[23:12];
    assign in_ref   = s_tdata[35:24];
    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Sample window: chain of cells, newest at the head. A running sum
    // adds the new sample and drops the one falling off the tail once
    // the window is full.
    // ------------------------------------------------------------------
    sample_t chain [0:WINDOW];
    logic    window_full;

    assign chain[0].tap_mv = in_tap;
    assign chain[0].ref_mv = in_ref;
    assign window_full     = (fill_reg == FILL_W'(WINDOW));

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW; gi++)
        begin : g_cell
            brg_cell u_cell (
                .clk   (clk),
                .shift (s_accept),
                .din   (chain[gi]),
                .dout  (chain[gi+1])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // Shared divider and its operand selection
    // ------------------------------------------------------------------
    div_ctrl_t        div_ctrl;
    div_stat_t        div_stat;
    logic [Q_W-1:0]   div_dividend;
    logic [DVS_W-1:0] div_divisor;
    logic [Q_W-1:0]   div_quotient;

    always_comb
    begin
        div_ctrl.start = 1'b0;
        div_ctrl.iters = CNT_W'(SUM_W);
        div_dividend   = Q_W'(tap_sum_reg) << AVG_SHIFT;
        div_divisor    = DVS_W'(fill_reg);
        case (state_reg)
            S_TAP_GO:
            begin
                div_ctrl.start = 1'b1;
            end
            S_REF_GO:
            begin
                div_ctrl.start = 1'b1;
                div_dividend   = Q_W'(ref_sum_reg) << AVG_SHIFT;
            end
            S_Q_GO:
            begin
                div_ctrl.start = 1'b1;
                div_ctrl.iters = CNT_W'(Q_W);
                div_dividend   = Q_W'(prod_reg) << (FRAC_BITS + 1);
                div_divisor    = avg_ref_reg;
            end
            default:
            begin
                div_ctrl.start = 1'b0;
            end
        endcase
    end

    brg_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    // ------------------------------------------------------------------
    // Final rounding, saturation and percent
    // ------------------------------------------------------------------
    logic                 out_free;
    logic                 invalid;
    logic [Q_W:0]         mv_sum;
    logic [Q_W-FRAC_BITS:0] mv_full;
    logic [MV_W-1:0]      mv_sat;
    logic [Q_W-1:0]       base;
    logic [Q_W:0]         pdiff;
    logic [Q_W-FRAC_BITS-3:0] pq;
    logic [PCT_W-1:0]     pct;
    logic                 changed;

    assign out_free = !m_tvalid_reg || m_tready;
    assign invalid  = !charging_reg && (avg_ref_reg == '0);
    assign mv_sum   = {1'b0, q_reg} + (Q_W+1)'(1 << (FRAC_BITS - 1));
    assign mv_full  = mv_sum[Q_W:FRAC_BITS];
    assign mv_sat   = (mv_full > (Q_W-FRAC_BITS+1)'(MV_MAX)) ? MV_MAX : mv_full[MV_W-1:0];
    assign base     = Q_W'(empty_reg) << FRAC_BITS;
    // (q - base + half step) / step, step = 8 mV at 8 fraction bits
    assign pdiff    = {1'b0, q_reg - base} + (Q_W+1)'(1 << (FRAC_BITS + 2));
    assign pq       = pdiff[Q_W:FRAC_BITS+3];
    assign pct      = (q_reg < base) ? '0 :
                      (pq > (Q_W-FRAC_BITS-2)'(PCT_MAX)) ? PCT_MAX : pq[PCT_W-1:0];
    assign changed  = !rep_valid_reg || (pct != rep_pct_reg) ||
                      (charging_reg != rep_chg_reg);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = S_TAP_GO;
                end
            end
            S_TAP_GO:
            begin
                state_next = S_TAP_WAIT;
            end
            S_TAP_WAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = S_REF_GO;
                end
            end
            S_REF_GO:
            begin
                state_next = S_REF_WAIT;
            end
            S_REF_WAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (charging_reg || (avg_ref_reg == '0))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_Q_GO;
                end
            end
            S_Q_GO:
            begin
                state_next = S_Q_WAIT;
            end
            S_Q_WAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            nom_reg       <= NOM_RESET;
            thr_reg       <= THR_RESET;
            empty_reg     <= EMPTY_RESET;
            fill_reg      <= '0;
            tap_sum_reg   <= '0;
            ref_sum_reg   <= '0;
            held_mv_reg   <= FULL_MV;
            held_pct_reg  <= PCT_MAX;
            rep_pct_reg   <= '0;
            rep_valid_reg <= 1'b0;
            rep_chg_reg   <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_addr)
                    CFG_REF_NOMINAL: nom_reg   <= cfg_data[NOM_W-1:0];
                    CFG_CHARGE_THR:  thr_reg   <= cfg_data[THR_W-1:0];
                    CFG_EMPTY_MV:    empty_reg <= cfg_data[EMPTY_W-1:0];
                    default:         nom_reg   <= nom_reg;
                endcase
            end

            // Advance the window on every accepted beat
            if (s_accept)
            begin
                tap_sum_reg <= tap_sum_reg + SUM_W'(in_tap)
                               - (window_full ? SUM_W'(chain[WINDOW].tap_mv) : '0);
                ref_sum_reg <= ref_sum_reg + SUM_W'(in_ref)
                               - (window_full ? SUM_W'(chain[WINDOW].ref_mv) : '0);
                if (!window_full)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end

            if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            if ((state_reg == S_FIN) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
                if (!invalid)
                begin
                    held_mv_reg  <= mv_sat;
                    held_pct_reg <= pct;
                    if (changed)
                    begin
                        rep_valid_reg <= 1'b1;
                        rep_pct_reg   <= pct;
                        rep_chg_reg   <= charging_reg;
                    end
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            charging_reg <= (in_code > thr_reg);
        end
        if ((state_reg == S_TAP_WAIT) && div_stat.done)
        begin
            avg_tap_reg <= div_quotient[TAP_W-1:0];
        end
        if ((state_reg == S_REF_WAIT) && div_stat.done)
        begin
            avg_ref_reg <= div_quotient[REFMV_W-1:0];
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= avg_tap_reg * nom_reg;
            q_reg    <= Q_W'(avg_tap_reg) << (FRAC_BITS + 1);
        end
        if ((state_reg == S_Q_WAIT) && div_stat.done)
        begin
            q_reg <= div_quotient;
        end
        if ((state_reg == S_FIN) && out_free)
        begin
            if (invalid)
            begin
                m_tdata_reg <= {1'b0, 1'b0, 1'b0, held_pct_reg, held_mv_reg};
            end
            else
            begin
                m_tdata_reg <= {1'b1, changed, charging_reg, pct, mv_sat};
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The window is never empty while a beat is being worked
    a_fill_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (fill_reg != '0))
        else $error("window empty during processing");

    // The divider runs only while the sequencer waits on it
    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> ((state_reg == S_TAP_WAIT) || (state_reg == S_REF_WAIT) ||
                           (state_reg == S_Q_WAIT)))
        else $error("divider busy outside a wait step");

    // A held (invalid) result never reports a change
    a_invalid_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[23]) |-> (!m_tdata[22] && !m_tdata[21]))
        else $error("invalid result flagged changed or charging");

    // Percent stays within its range
    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[20:14] <= PCT_MAX))
        else $error("percent out of range");

endmodule

`default_nettype wire
